@@ hdl/days_between_dates_core_macros.svh @@
// Assertion macros shared by the day-count pipeline.
`ifndef DAYS_BETWEEN_DATES_CORE_MACROS_SVH
`define DAYS_BETWEEN_DATES_CORE_MACROS_SVH

// Same-cycle implication.
`define DBD_ASSERT_IMPLIES(name, clk, rst, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// Next-cycle implication.
`define DBD_ASSERT_NEXT(name, clk, rst, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

@@ hdl/dbd_pkg.sv @@
// Shared constants, types and calendar tables for the day-count pipeline.
package dbd_pkg;

  localparam int YEAR_BITS  = 14;
  localparam int DAY_BITS   = 5;
  localparam int MONTH_BITS = 4;
  localparam int COUNT_BITS = 23;

  localparam int YEAR_OFFSET = 400;
  localparam int YY_BITS     = $clog2((1 << YEAR_BITS) + YEAR_OFFSET);
  localparam int DIV_SHIFT   = YY_BITS;
  localparam int MUL_BITS    = DIV_SHIFT - 6;
  localparam int PROD_BITS   = YY_BITS + MUL_BITS;
  localparam int Q_BITS      = YY_BITS - 6;
  localparam int OFF_BITS    = 9;
  localparam int DN_BITS     = YY_BITS + 9;
  localparam int DIFF_BITS   = (DN_BITS > COUNT_BITS) ? DN_BITS : COUNT_BITS + 1;

  localparam logic [MUL_BITS-1:0] DIV_MUL = MUL_BITS'((1 << DIV_SHIFT) / 100);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);

  // Stages: 0..4 per-date path, 5 output register.
  localparam int NUM_STAGES = 6;

  typedef struct packed {
    logic [NUM_STAGES-1:0] valid;
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m);
    logic [DAY_BITS-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a March-based year.
  function automatic logic [OFF_BITS-1:0] month_offset(input logic [MONTH_BITS-1:0] m);
    logic [OFF_BITS-1:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ hdl/dbd_if.sv @@
// Valid/ready channel interfaces for date pairs and day-count results.
interface dbd_in_if import dbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DAY_BITS-1:0]   first_day;
  logic [MONTH_BITS-1:0] first_month;
  logic [YEAR_BITS-1:0]  first_year;
  logic [DAY_BITS-1:0]   second_day;
  logic [MONTH_BITS-1:0] second_month;
  logic [YEAR_BITS-1:0]  second_year;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

interface dbd_out_if import dbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  invalid;
  logic [COUNT_BITS-1:0] day_count;

  modport source (output valid, invalid, day_count, input ready);
  modport sink (input valid, invalid, day_count, output ready);
endinterface

@@ hdl/dbd_pipe_ctl.sv @@
// Valid bits and per-stage load enables of the pipeline.
`include "days_between_dates_core_macros.svh"

module dbd_pipe_ctl import dbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] load;
  logic [NUM_STAGES-1:0] valid_prev;

  // A stage loads when empty or when its content moves on.
  always_comb begin
    load[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  assign valid_prev = {valid[NUM_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid_prev[i];
        end
      end
    end
  end

  assign in_ready  = load[0];
  assign ctl.valid = valid;
  assign ctl.load  = load;

  `DBD_ASSERT_IMPLIES(a_no_overwrite, clk, rst, 1'b1, (valid[NUM_STAGES-2:0] & load[NUM_STAGES-2:0] & ~load[NUM_STAGES-1:1]) == '0)
  `DBD_ASSERT_IMPLIES(a_reset_empty, clk, rst, $past(rst), valid == '0)
  `DBD_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, valid[0])

endmodule

@@ hdl/dbd_date_path.sv @@
// Per-date pipeline: validity check and closed-form day number.
module dbd_date_path import dbd_pkg::*; (
  input  logic                  clk,
  input  pipe_ctl_t             ctl,
  input  logic [DAY_BITS-1:0]   day,
  input  logic [MONTH_BITS-1:0] month,
  input  logic [YEAR_BITS-1:0]  year,
  output logic [DN_BITS-1:0]    day_num,
  output logic                  ok
);

  logic [DAY_BITS-1:0]   s0_day, s1_day, s2_day;
  logic [MONTH_BITS-1:0] s0_month, s1_month, s2_month;
  logic [YY_BITS-1:0]    s0_yy, s1_yy, s2_yy, s3_yy;
  logic                  s0_ok, s1_ok, s2_ok, s3_ok;
  logic [PROD_BITS-1:0]  s1_prod;
  logic [Q_BITS-1:0]     s2_q, s3_q;
  logic [7:0]            s2_r;
  logic [OFF_BITS-1:0]   s3_off;

  logic [Q_BITS-1:0]     q_est;
  logic [YY_BITS-1:0]    r_est;
  logic                  r_over;
  logic [Q_BITS-1:0]     q_fix;
  logic [7:0]            r_fix;
  logic                  is_feb;
  logic                  leap;
  logic [DAY_BITS-1:0]   len;

  // Year shifted by 400, one less for January and February.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s0_day   <= day;
      s0_month <= month;
      s0_ok    <= (month >= MONTH_JAN) && (month <= MONTH_DEC) && (day != '0);
      s0_yy    <= YY_BITS'(year) + YY_BITS'(YEAR_OFFSET)
                  - YY_BITS'(month <= MONTH_FEB);
    end
  end

  // Reciprocal multiply for yy / 100.
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s1_prod  <= PROD_BITS'(s0_yy) * PROD_BITS'(DIV_MUL);
      s1_yy    <= s0_yy;
      s1_day   <= s0_day;
      s1_month <= s0_month;
      s1_ok    <= s0_ok;
    end
  end

  assign q_est = s1_prod[DIV_SHIFT +: Q_BITS];
  assign r_est = s1_yy - YY_BITS'(YY_BITS'(q_est) * YY_BITS'(100));

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s2_q     <= q_est;
      s2_r     <= r_est[7:0];
      s2_yy    <= s1_yy;
      s2_day   <= s1_day;
      s2_month <= s1_month;
      s2_ok    <= s1_ok;
    end
  end

  // Quotient estimate is low by at most one.
  assign r_over = s2_r >= 8'd100;
  assign q_fix  = r_over ? s2_q + Q_BITS'(1) : s2_q;
  assign r_fix  = r_over ? s2_r - 8'd100 : s2_r;

  // For February yy + 1 is the year plus 400, so test leap on yy + 1.
  assign is_feb = s2_month == MONTH_FEB;
  assign leap   = ((s2_yy[1:0] == 2'd3) && (r_fix != 8'd99))
                  || ((q_fix[1:0] == 2'd3) && (r_fix == 8'd99));
  assign len    = month_len(s2_month) + DAY_BITS'(is_feb && leap);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s3_yy  <= s2_yy;
      s3_q   <= q_fix;
      s3_off <= month_offset(s2_month) + OFF_BITS'(s2_day);
      s3_ok  <= s2_ok && (s2_day <= len);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      day_num <= DN_BITS'(s3_yy) * DN_BITS'(365) + DN_BITS'(s3_yy >> 2)
                 - DN_BITS'(s3_q) + DN_BITS'(s3_q >> 2) + DN_BITS'(s3_off);
      ok      <= s3_ok;
    end
  end

endmodule

@@ hdl/days_between_dates_core.sv @@
// Days between two Gregorian dates, fully pipelined.
// Throughput: one transaction per cycle while result is ready; each stage has its
// own valid bit and loads when empty or draining, so a stall backs up without loss.
// Reset (rst, synchronous): clears all valid bits; datapath registers are not reset.
`include "days_between_dates_core_macros.svh"

module days_between_dates_core import dbd_pkg::*; (
  input logic      clk,
  input logic      rst,
  dbd_in_if.sink   dates,
  dbd_out_if.source result
);

  pipe_ctl_t            ctl;
  logic [DN_BITS-1:0]   first_num, second_num;
  logic                 first_ok, second_ok;
  logic [DIFF_BITS-1:0] num_a, num_b, diff;
  logic                 res_invalid;
  logic [COUNT_BITS-1:0] res_count;

  dbd_pipe_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dates.valid),
    .out_ready (result.ready),
    .in_ready  (dates.ready),
    .ctl       (ctl)
  );

  dbd_date_path u_first (
    .clk     (clk),
    .ctl     (ctl),
    .day     (dates.first_day),
    .month   (dates.first_month),
    .year    (dates.first_year),
    .day_num (first_num),
    .ok      (first_ok)
  );

  dbd_date_path u_second (
    .clk     (clk),
    .ctl     (ctl),
    .day     (dates.second_day),
    .month   (dates.second_month),
    .year    (dates.second_year),
    .day_num (second_num),
    .ok      (second_ok)
  );

  assign num_a = DIFF_BITS'(first_num);
  assign num_b = DIFF_BITS'(second_num);
  assign diff  = (num_a >= num_b) ? num_a - num_b : num_b - num_a;

  always_ff @(posedge clk) begin
    if (ctl.load[NUM_STAGES-1]) begin
      res_invalid <= !(first_ok && second_ok);
      if (!(first_ok && second_ok)) begin
        res_count <= '0;
      end else if (diff > DIFF_BITS'(COUNT_MAX)) begin
        res_count <= COUNT_MAX;
      end else begin
        res_count <= diff[COUNT_BITS-1:0];
      end
    end
  end

  assign result.valid     = ctl.valid[NUM_STAGES-1];
  assign result.invalid   = res_invalid;
  assign result.day_count = res_count;

  `DBD_ASSERT_IMPLIES(a_invalid_zero, clk, rst, result.valid && result.invalid, result.day_count == '0)

endmodule

@@ tb/tb_days_between_dates_core.sv @@
// Testbench for days_between_dates_core: directed and random date pairs checked against a predictor.
module tb_days_between_dates_core import dbd_pkg::*; ();

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
  } date_t;

  typedef struct packed {
    logic                  invalid;
    logic [COUNT_BITS-1:0] day_count;
  } span_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  bit          steady = 1'b0;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  span_t       pending_spans[$];

  dbd_in_if  dates_if ();
  dbd_out_if result_if ();

  days_between_dates_core dut (
    .clk    (clk),
    .rst    (rst),
    .dates  (dates_if),
    .result (result_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_ok(input date_t dt);
    return dt.day != 0 && dt.day <= month_days(dt.month, dt.year);
  endfunction

  // Day index from a fixed epoch; year shifted by one Gregorian cycle, March-based months.
  function automatic longint unsigned epoch_day(input date_t dt);
    longint unsigned yy;
    longint unsigned mm;
    yy = longint'(dt.year) + 400 - ((dt.month <= MONTH_FEB) ? 1 : 0);
    mm = (longint'(dt.month) + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mm + 2) / 5 + dt.day;
  endfunction

  function automatic span_t predict_span(input date_t a, input date_t b);
    longint unsigned da;
    longint unsigned db;
    longint unsigned diff;
    span_t           s;
    if (!date_ok(a) || !date_ok(b)) begin
      s.invalid   = 1'b1;
      s.day_count = '0;
      return s;
    end
    da   = epoch_day(a);
    db   = epoch_day(b);
    diff = (da >= db) ? da - db : db - da;
    if (diff > (64'd1 << COUNT_BITS) - 1) diff = (64'd1 << COUNT_BITS) - 1;
    s.invalid   = 1'b0;
    s.day_count = diff[COUNT_BITS-1:0];
    return s;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_t mk(input int unsigned d, input int unsigned m, input int unsigned y);
    date_t dt;
    dt.day   = d[DAY_BITS-1:0];
    dt.month = m[MONTH_BITS-1:0];
    dt.year  = y[YEAR_BITS-1:0];
    return dt;
  endfunction

  function automatic int unsigned pick_year();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, (1 << YEAR_BITS) - 1);
    if (r < 8) return $urandom_range(0, 163) * 100 + $urandom_range(0, 4);
    if (r == 8) return $urandom_range(0, 8);
    return (1 << YEAR_BITS) - 1 - $urandom_range(0, 8);
  endfunction

  function automatic date_t pick_date();
    int unsigned m;
    int unsigned y;
    int unsigned len;
    m   = $urandom_range(MONTH_JAN, MONTH_DEC);
    y   = pick_year();
    len = month_days(m, y);
    return mk(($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len), m, y);
  endfunction

  function automatic date_t pick_raw();
    return mk($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
  endfunction

  // Valid date with one thing broken.
  function automatic date_t break_date(input date_t dt);
    int unsigned len;
    len = month_days(dt.month, dt.year);
    case ($urandom_range(0, 3))
      0: dt.day = (len < 31) ? DAY_BITS'(len + 1) : '0;
      1: dt.day = '0;
      2: dt.month = ($urandom_range(0, 1) == 0) ? '0 : MONTH_BITS'($urandom_range(13, 15));
      default: dt = mk(29, MONTH_FEB, $urandom_range(0, 4095) * 4 + $urandom_range(1, 3));
    endcase
    return dt;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("ERROR %s: expected %0d, got %0d at %0t", what, want, got, $time);
    mismatches++;
  endtask

  task automatic send_pair(input date_t a, input date_t b);
    int unsigned gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      dates_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    dates_if.first_day    = a.day;
    dates_if.first_month  = a.month;
    dates_if.first_year   = a.year;
    dates_if.second_day   = b.day;
    dates_if.second_month = b.month;
    dates_if.second_year  = b.year;
    dates_if.valid        = 1'b1;
    @(posedge clk);
    while (!dates_if.ready) @(posedge clk);
    pending_spans.push_back(predict_span(a, b));
    @(negedge clk);
  endtask

  // Stop sending, wait until every pending result is back, then let the pipeline idle.
  task automatic drain_results();
    dates_if.valid = 1'b0;
    while (pending_spans.size() != 0) @(negedge clk);
    repeat (NUM_STAGES + 6) @(negedge clk);
  endtask

  task automatic test_directed();
    send_pair(mk(1, 1, 2000), mk(1, 1, 2000));
    send_pair(mk(29, 2, 2000), mk(1, 3, 2000));
    send_pair(mk(29, 2, 1900), mk(1, 3, 1900));
    send_pair(mk(28, 2, 2023), mk(29, 2, 2024));
    send_pair(mk(1, 1, 2023), mk(29, 2, 2023));
    send_pair(mk(28, 2, 2100), mk(1, 3, 2100));
    send_pair(mk(29, 2, 2400), mk(29, 2, 2000));
    send_pair(mk(0, 5, 100), mk(1, 5, 100));
    send_pair(mk(1, 0, 100), mk(1, 5, 100));
    send_pair(mk(1, 5, 100), mk(1, 13, 100));
    send_pair(mk(1, 15, 16383), mk(1, 1, 16383));
    send_pair(mk(31, 4, 2001), mk(30, 4, 2001));
    send_pair(mk(30, 4, 2001), mk(31, 5, 2001));
    send_pair(mk(31, 12, 16383), mk(1, 1, 0));
    send_pair(mk(1, 1, 0), mk(31, 12, 16383));
    send_pair(mk(29, 2, 0), mk(1, 3, 0));
    send_pair(mk(29, 2, 16383), mk(29, 2, 16000));
    send_pair(mk(31, 1, 1), mk(1, 2, 1));
    send_pair(mk(31, 15, 16383), mk(31, 15, 16383));
    send_pair(mk(0, 0, 0), mk(0, 0, 0));
    send_pair(mk(15, 6, 8191), mk(15, 6, 8192));
    drain_results();
  endtask

  task automatic test_random_valid();
    repeat (1030) begin
      if ($urandom_range(0, 9) == 0) send_pair(pick_date(), pick_raw());
      else send_pair(pick_date(), pick_date());
    end
    drain_results();
  endtask

  task automatic test_broken_dates();
    repeat (200) begin
      if ($urandom_range(0, 1) == 0) send_pair(break_date(pick_date()), pick_date());
      else send_pair(pick_date(), break_date(pick_date()));
    end
    drain_results();
  endtask

  task automatic test_raw_fields();
    repeat (300) send_pair(pick_raw(), pick_raw());
    drain_results();
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (200) send_pair(pick_date(), pick_date());
    steady = 1'b0;
    drain_results();
  endtask

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady) begin
        result_if.ready = 1'b0;
        stall_left--;
      end else begin
        result_if.ready = 1'b1;
        stall_left = 0;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin : check_results
    span_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("result with no transaction pending", 0, result_if.day_count);
      end else begin
        want = pending_spans.pop_front();
        if (result_if.invalid !== want.invalid)
          report_mismatch("invalid", want.invalid, result_if.invalid);
        if (result_if.day_count !== want.day_count)
          report_mismatch("day_count", want.day_count, result_if.day_count);
      end
    end
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    dates_if.valid        = 1'b0;
    dates_if.first_day    = '0;
    dates_if.first_month  = '0;
    dates_if.first_year   = '0;
    dates_if.second_day   = '0;
    dates_if.second_month = '0;
    dates_if.second_year  = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_valid();
    test_broken_dates();
    test_raw_fields();
    test_back_to_back();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
